[src/wol_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wol_pkg
// Shared types and constants for the Wake-on-LAN magic packet detector.
// ----------------------------------------------------------------------------
package wol_pkg;

	localparam int unsigned POS_W     = 7;   // byte position, saturating
	localparam int unsigned FF_W      = 3;   // header 0xFF byte count
	localparam int unsigned CNT_W     = 5;   // matching group count
	localparam int unsigned GRP_IDX_W = 3;   // byte index inside a group
	localparam int unsigned ADDR_W    = 48;  // station address width

	localparam int unsigned HEADER_BYTES = 6;
	localparam int unsigned ADDR_BYTES   = 6;
	localparam logic [7:0]  BYTE_ONES    = 8'hFF;

	localparam int unsigned DEF_MAX_PACKET_BYTES = 112;
	localparam int unsigned DEF_ADDRESS_REPEATS  = 16;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_packet;
	} wol_in_t;

	typedef struct packed {
		logic             header_ok;
		logic [CNT_W-1:0] address_matches;
		logic             wake;
	} wol_out_t;

endpackage : wol_pkg
`default_nettype wire

[src/wake_on_lan_magic_packet_detector_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wake_on_lan_magic_packet_detector_unit
// Byte-serial magic packet checker with a two-entry result buffer.
// ----------------------------------------------------------------------------
// Takes a datagram payload one item (byte) per clock and reports on the last
// byte of each packet: header_ok when bytes 0..5 are all 0xFF, the number of
// complete 6-byte groups that equal station_address (forced to 0 with a bad
// header), and wake when the header is good and all ADDRESS_REPEATS groups
// matched. Bytes beyond the last group, and at or past MAX_PACKET_BYTES, are
// ignored. One byte is taken every cycle while in_ready is high: the per-packet
// counters update in a single pass of short logic at each accepted byte, and
// the result is registered into the output entry, or into the skid entry while
// the output is stalled. The skid entry behind the output register keeps the
// input open while a result waits; in_ready drops only when both entries hold
// results not yet taken. A write on cfg_we replaces the address at once; bytes
// after it compare against the new value.
// ----------------------------------------------------------------------------
module wake_on_lan_magic_packet_detector_unit
	import wol_pkg::*;
#(
	parameter int unsigned MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES,
	parameter int unsigned ADDRESS_REPEATS  = DEF_ADDRESS_REPEATS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              cfg_we,
	input  wire logic [ADDR_W-1:0] cfg_wdata,
	// byte input
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire wol_in_t           in_data,
	// packet result
	output logic                   out_valid,
	input  wire logic              out_ready,
	output wol_out_t               out_data
);

	// position where the address groups end, and the saturation limit
	localparam logic [POS_W-1:0] GROUP_END =
		POS_W'(HEADER_BYTES + ADDR_BYTES * ADDRESS_REPEATS);
	localparam logic [POS_W-1:0] MAX_POS    = POS_W'(MAX_PACKET_BYTES);
	localparam logic [POS_W-1:0] HDR_END    = POS_W'(HEADER_BYTES);
	localparam logic [FF_W-1:0]  FF_FULL    = FF_W'(HEADER_BYTES);
	localparam logic [GRP_IDX_W-1:0] GRP_LAST = GRP_IDX_W'(ADDR_BYTES - 1);
	localparam logic [CNT_W-1:0] CNT_ALL    = CNT_W'(ADDRESS_REPEATS);

	// configuration register
	logic [ADDR_W-1:0]    station_address_q;

	// packet state
	logic [POS_W-1:0]     pos_q,      pos_d;
	logic [FF_W-1:0]      ff_cnt_q,   ff_cnt_d;
	logic [CNT_W-1:0]     match_q,    match_d;
	logic                 grp_eq_q,   grp_eq_d;
	logic [GRP_IDX_W-1:0] grp_idx_q,  grp_idx_d;

	// result buffer: output entry and skid entry
	logic                 out_vld_q;
	wol_out_t             out_q;
	logic                 skid_vld_q;
	wol_out_t             skid_q;

	logic                 in_acc;
	logic                 out_pop;
	logic                 push;
	logic [7:0]           want_byte;
	logic                 byte_eq;
	logic                 hdr_ok;
	wol_out_t             res;

	assign in_ready = !skid_vld_q;
	assign in_acc   = in_valid && in_ready;
	assign out_pop  = out_vld_q && out_ready;
	assign push     = in_acc && in_data.end_of_packet;

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// address byte for the current group slot, first byte in the top bits
	always_comb begin
		unique case (grp_idx_q)
			3'd0:    want_byte = station_address_q[47:40];
			3'd1:    want_byte = station_address_q[39:32];
			3'd2:    want_byte = station_address_q[31:24];
			3'd3:    want_byte = station_address_q[23:16];
			3'd4:    want_byte = station_address_q[15:8];
			default: want_byte = station_address_q[7:0];
		endcase
	end

	assign byte_eq = (in_data.data_byte == want_byte);

	// next packet state for the byte at the input
	always_comb begin
		pos_d     = pos_q;
		ff_cnt_d  = ff_cnt_q;
		match_d   = match_q;
		grp_eq_d  = grp_eq_q;
		grp_idx_d = grp_idx_q;
		if (pos_q < MAX_POS) begin
			pos_d = pos_q + POS_W'(1);
			if (pos_q < HDR_END) begin
				if (in_data.data_byte == BYTE_ONES) begin
					ff_cnt_d = ff_cnt_q + FF_W'(1);
				end
			end else if (pos_q < GROUP_END) begin
				if (grp_idx_q == GRP_LAST) begin
					// group complete: count it and restart
					if (grp_eq_q && byte_eq) begin
						match_d = match_q + CNT_W'(1);
					end
					grp_eq_d  = 1'b1;
					grp_idx_d = '0;
				end else begin
					grp_eq_d  = grp_eq_q && byte_eq;
					grp_idx_d = grp_idx_q + GRP_IDX_W'(1);
				end
			end
		end
	end

	// result from the updated counters
	always_comb begin
		hdr_ok              = (ff_cnt_d == FF_FULL);
		res.header_ok       = hdr_ok;
		res.address_matches = hdr_ok ? match_d : '0;
		res.wake            = hdr_ok && (match_d == CNT_ALL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_address_q <= '0;
		end else if (cfg_we) begin
			station_address_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			ff_cnt_q  <= '0;
			match_q   <= '0;
			grp_eq_q  <= 1'b1;
			grp_idx_q <= '0;
		end else if (in_acc) begin
			if (in_data.end_of_packet) begin
				// packet done: clear for the next one
				pos_q     <= '0;
				ff_cnt_q  <= '0;
				match_q   <= '0;
				grp_eq_q  <= 1'b1;
				grp_idx_q <= '0;
			end else begin
				pos_q     <= pos_d;
				ff_cnt_q  <= ff_cnt_d;
				match_q   <= match_d;
				grp_eq_q  <= grp_eq_d;
				grp_idx_q <= grp_idx_d;
			end
		end
	end

	// result buffer control; skid entry only fills while output is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_pop) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end
		end else if (out_vld_q && !out_pop) begin
			skid_vld_q <= push;
		end else begin
			out_vld_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_pop) begin
				out_q <= skid_q;
			end
		end else if (out_vld_q && !out_pop) begin
			if (push) begin
				skid_q <= res;
			end
		end else if (push) begin
			out_q <= res;
		end
	end

endmodule : wake_on_lan_magic_packet_detector_unit
`default_nettype wire
